[hdl/gha_pkg.sv]
// Shared types and codes for the generational handle allocator.
package gha_pkg;

    typedef enum logic [1:0] {
        ACT_GRANT   = 2'd0,
        ACT_RECYCLE = 2'd1,
        ACT_LOOKUP  = 2'd2,
        ACT_RESERVE = 2'd3
    } t_action;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_STALE = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_BUMP,
        S_CHECK
    } t_state;

    // What the datapath finishes with in the current cycle.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_RESERVE,
        RES_FREE,
        RES_LOOKUP,
        RES_FRESH,
        RES_BUMP,
        RES_FULL,
        RES_STALE
    } t_res;

    typedef struct packed {
        logic latch;
        logic clr;
        logic pop;
        t_res res;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    has_free;
        logic    fresh_ok;
        logic    in_range;
        logic    match;
        logic    clr_last;
    } t_stat;

endpackage

[hdl/gha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/gha_ctrl.sv]
// Sequencer that steps each request through the slot table and free stack.
module gha_ctrl import gha_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                case (i_stat.action)
                    ACT_GRANT: begin
                        if (i_stat.has_free) n_state = S_POP;
                    end
                    ACT_RECYCLE, ACT_LOOKUP: begin
                        if (i_stat.in_range) n_state = S_CHECK;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_POP:   n_state = S_BUMP;
            S_BUMP:  n_state = S_IDLE;
            S_CHECK: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.res   = RES_NONE;
        o_busy      = 1'b1;
        case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.latch = i_start;
            end
            S_DISPATCH: begin
                case (i_stat.action)
                    ACT_GRANT: begin
                        if (i_stat.has_free) begin
                            o_cmd.res = RES_NONE;
                        end else if (i_stat.fresh_ok) begin
                            o_cmd.res = RES_FRESH;
                        end else begin
                            o_cmd.res = RES_FULL;
                        end
                    end
                    ACT_RECYCLE, ACT_LOOKUP: begin
                        if (!i_stat.in_range) o_cmd.res = RES_STALE;
                    end
                    ACT_RESERVE: begin
                        o_cmd.res = i_stat.in_range ? RES_RESERVE : RES_STALE;
                    end
                    default: o_cmd.res = RES_NONE;
                endcase
            end
            S_POP:  o_cmd.pop = 1'b1;
            S_BUMP: o_cmd.res = RES_BUMP;
            S_CHECK: begin
                if (!i_stat.match) begin
                    o_cmd.res = RES_STALE;
                end else if (i_stat.action == ACT_RECYCLE) begin
                    o_cmd.res = RES_FREE;
                end else begin
                    o_cmd.res = RES_LOOKUP;
                end
            end
            default: o_cmd.res = RES_NONE;
        endcase
    end

endmodule

[hdl/gha_dp.sv]
// Datapath: slot table, payload store, free stack, counters and result register.
module gha_dp import gha_pkg::*; #(
    parameter int MAX_IDS      = 1024,
    parameter int VERSION_BITS = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [1:0]                 i_action,
    input  logic [$clog2(MAX_IDS)-1:0] i_handle_id,
    input  logic [VERSION_BITS-1:0]    i_handle_version,
    input  logic [PAYLOAD_BITS-1:0]    i_payload,
    output t_stat                      o_stat,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [$clog2(MAX_IDS)-1:0] o_out_id,
    output logic [VERSION_BITS-1:0]    o_out_version,
    output logic [PAYLOAD_BITS-1:0]    o_out_payload
);

    localparam int ID_BITS  = $clog2(MAX_IDS);
    localparam int CNT_BITS = $clog2(MAX_IDS + 1);
    localparam int TW       = VERSION_BITS + 1;
    localparam logic [ID_BITS-1:0]  LAST_ID = ID_BITS'(MAX_IDS - 1);
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_IDS);

    t_action                 r_action;
    logic [ID_BITS-1:0]      r_id;
    logic [VERSION_BITS-1:0] r_ver;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [CNT_BITS-1:0]     r_count;
    logic [ID_BITS-1:0]      r_highest;
    logic [ID_BITS-1:0]      r_gid;
    logic [ID_BITS-1:0]      r_clr;

    logic                    r_done;
    logic [1:0]              r_status;
    logic [ID_BITS-1:0]      r_oid;
    logic [VERSION_BITS-1:0] r_over;
    logic [PAYLOAD_BITS-1:0] r_opay;

    logic                    tbl_we;
    logic [ID_BITS-1:0]      tbl_waddr;
    logic [TW-1:0]           tbl_wdata;
    logic [ID_BITS-1:0]      tbl_raddr;
    logic [TW-1:0]           tbl_rdata;
    logic                    pay_we;
    logic [ID_BITS-1:0]      pay_waddr;
    logic [PAYLOAD_BITS-1:0] pay_rdata;
    logic                    stk_we;
    logic [ID_BITS-1:0]      stk_raddr;
    logic [ID_BITS-1:0]      stk_rdata;
    logic [CNT_BITS-1:0]     count_dec;
    logic [ID_BITS-1:0]      fresh_id;
    logic [VERSION_BITS-1:0] bump_ver;
    logic                    room;

    assign count_dec = r_count - CNT_BITS'(1);
    assign stk_raddr = count_dec[ID_BITS-1:0];
    assign fresh_id  = r_highest + ID_BITS'(1);
    assign bump_ver  = tbl_rdata[VERSION_BITS-1:0] + VERSION_BITS'(1);
    assign room      = (r_count != CNT_MAX);

    assign o_stat.action   = r_action;
    assign o_stat.has_free = (r_count != '0);
    assign o_stat.fresh_ok = (r_highest < LAST_ID);
    assign o_stat.in_range = (CNT_BITS'(r_id) < CNT_MAX);
    assign o_stat.match    = tbl_rdata[TW-1] && (tbl_rdata[VERSION_BITS-1:0] == r_ver);
    assign o_stat.clr_last = (r_clr == LAST_ID);

    // The table read address follows the popped id while a reused slot is fetched.
    assign tbl_raddr = i_cmd.pop ? stk_rdata : r_id;

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_id;
        tbl_wdata = '0;
        pay_we    = 1'b0;
        pay_waddr = r_id;
        stk_we    = 1'b0;
        if (i_cmd.clr) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_clr;
        end else begin
            case (i_cmd.res)
                RES_FRESH: begin
                    tbl_we    = 1'b1;
                    tbl_waddr = fresh_id;
                    tbl_wdata = {1'b1, {VERSION_BITS{1'b0}}};
                    pay_we    = 1'b1;
                    pay_waddr = fresh_id;
                end
                RES_BUMP: begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_gid;
                    tbl_wdata = {1'b1, bump_ver};
                    pay_we    = 1'b1;
                    pay_waddr = r_gid;
                end
                RES_FREE: begin
                    tbl_we    = 1'b1;
                    tbl_wdata = {1'b0, tbl_rdata[VERSION_BITS-1:0]};
                    stk_we    = room;
                end
                default: tbl_we = 1'b0;
            endcase
        end
    end

    gha_ram #(.WIDTH(TW), .DEPTH(MAX_IDS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    gha_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(MAX_IDS)) u_pay (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (r_pay),
        .i_raddr (r_id),
        .o_rdata (pay_rdata)
    );

    gha_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_IDS)) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_count[ID_BITS-1:0]),
        .i_wdata (r_id),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= t_action'(i_action);
            r_id     <= i_handle_id;
            r_ver    <= i_handle_version;
            r_pay    <= i_payload;
        end
        if (i_cmd.pop) begin
            r_gid <= stk_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_highest <= '0;
            r_clr     <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + ID_BITS'(1);
            end
            if (i_cmd.pop) begin
                r_count <= count_dec;
            end else if (i_cmd.res == RES_FREE && room) begin
                r_count <= r_count + CNT_BITS'(1);
            end
            if (i_cmd.res == RES_FRESH) begin
                r_highest <= fresh_id;
            end else if (i_cmd.res == RES_RESERVE && r_highest < r_id) begin
                r_highest <= r_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.res != RES_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res != RES_NONE) begin
            r_status <= STS_OK;
            r_oid    <= r_id;
            r_over   <= r_ver;
            r_opay   <= '0;
            case (i_cmd.res)
                RES_FRESH: begin
                    r_oid  <= fresh_id;
                    r_over <= '0;
                end
                RES_BUMP: begin
                    r_oid  <= r_gid;
                    r_over <= bump_ver;
                end
                RES_LOOKUP: r_opay   <= pay_rdata;
                RES_FULL:   r_status <= STS_FULL;
                RES_STALE:  r_status <= STS_STALE;
                default:    r_status <= STS_OK;
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_out_id      = r_oid;
    assign o_out_version = r_over;
    assign o_out_payload = r_opay;

endmodule

[hdl/generational_handle_allocator.sv]
// Top level of the generational handle allocator.
//
//  Channel   Handshake            Beat contents
//  request   i_start / o_busy     i_action, i_handle_id, i_handle_version, i_payload
//  result    o_done (strobe)      o_status, o_out_id, o_out_version, o_out_payload
//
// A request beat is taken at a clock edge where i_start is high and o_busy is low.
// Every request yields exactly one result beat, shown for one cycle with o_done.
// A fresh grant, a full grant, a reserve or an out-of-range handle ends in
// dispatch; a recycle or lookup adds a check state (one slot table read); a
// grant that reuses a freed id adds pop and bump states (a free stack read,
// then a slot table read). The result of one request is on the outputs in the
// same cycle the next request can be taken. After reset the block sweeps the
// live/version table, one entry a cycle, with o_busy high before its first request.
// The receiver cannot stall results; it must take each beat while o_done is high.
module generational_handle_allocator import gha_pkg::*; #(
    parameter int MAX_IDS      = 1024,
    parameter int VERSION_BITS = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [1:0]                 i_action,
    input  logic [$clog2(MAX_IDS)-1:0] i_handle_id,
    input  logic [VERSION_BITS-1:0]    i_handle_version,
    input  logic [PAYLOAD_BITS-1:0]    i_payload,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [$clog2(MAX_IDS)-1:0] o_out_id,
    output logic [VERSION_BITS-1:0]    o_out_version,
    output logic [PAYLOAD_BITS-1:0]    o_out_payload
);

    // Commands flow from the sequencer to the datapath, status flows back.
    t_cmd  cmd;
    t_stat stat;

    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    // The datapath holds the live/version table, the payload store, the LIFO
    // of freed ids with its fill count, the highest-id counter and the result
    // register. Only the live/version table is swept after reset; the payload
    // store and the stack are read only where they were written before.
    gha_dp #(
        .MAX_IDS      (MAX_IDS),
        .VERSION_BITS (VERSION_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_handle_id      (i_handle_id),
        .i_handle_version (i_handle_version),
        .i_payload        (i_payload),
        .o_stat           (stat),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_out_id         (o_out_id),
        .o_out_version    (o_out_version),
        .o_out_payload    (o_out_payload)
    );

endmodule

[bench/generational_handle_allocator_test.sv]
// Self-checking testbench for the generational handle allocator.
`timescale 1ns / 1ps

module generational_handle_allocator_test;
    import gha_pkg::*;

    localparam int         NUM_IDS    = 1024;
    localparam logic [9:0] TOP_ID     = 10'h3FF;
    localparam int         RANDOM_OPS = 1500;
    localparam int         WRAP_PAIRS = 258;

    // One result beat, laid out the same way as the result ports.
    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  id;
        logic [7:0]  ver;
        logic [31:0] pay;
    } t_handle_result;

    // One row of the directed sequence. When pinned is set, the typed result
    // replaces the predicted one for that beat.
    typedef struct {
        t_action        act;
        logic [9:0]     id;
        logic [7:0]     ver;
        logic [31:0]    pay;
        bit             pinned;
        t_handle_result res;
    } t_request_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_action = 2'd0;
    logic [9:0]  i_handle_id = 10'd0;
    logic [7:0]  i_handle_version = 8'd0;
    logic [31:0] i_payload = 32'd0;
    logic        o_busy;
    logic        o_done;
    logic [1:0]  o_status;
    logic [9:0]  o_out_id;
    logic [7:0]  o_out_version;
    logic [31:0] o_out_payload;

    generational_handle_allocator #(
        .MAX_IDS      (NUM_IDS),
        .VERSION_BITS (8),
        .PAYLOAD_BITS (32)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_action         (i_action),
        .i_handle_id      (i_handle_id),
        .i_handle_version (i_handle_version),
        .i_payload        (i_payload),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_out_id         (o_out_id),
        .o_out_version    (o_out_version),
        .o_out_payload    (o_out_payload)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the allocator state. It is advanced once per accepted
    // request beat, in the same order the block sees the requests.
    bit          slot_live [NUM_IDS];
    bit [7:0]    slot_ver  [NUM_IDS];
    bit [31:0]   slot_pay  [NUM_IDS];
    bit [9:0]    free_ids  [NUM_IDS];
    int          free_depth = 0;
    bit [9:0]    top_id = 10'd0;

    // Handles the shadow state considers live, used to build well-formed
    // recycles and lookups, plus the last handle freed so that double frees
    // and stale handles come up often.
    logic [9:0]  live_ids [$];
    logic [9:0]  last_freed_id = 10'd0;
    logic [7:0]  last_freed_ver = 8'd0;

    t_handle_result pending_results [$];
    int             fail_count = 0;

    // Idle pattern of the request side: runs of 20 to 60 beats, each run
    // either back to back or with a randomly drawn idle gap before each beat.
    int run_left = 0;
    bit run_dense = 1'b0;

    // Applies one request to the shadow state and returns the result beat
    // the block must produce for it.
    function automatic t_handle_result predict_handle_op(t_action act, logic [9:0] id,
                                                         logic [7:0] ver, logic [31:0] pay);
        t_handle_result r;
        logic [9:0]     gid;
        bit             granted;
        r = '{STS_OK, id, ver, 32'd0};
        case (act)
            ACT_GRANT: begin
                granted = 1'b1;
                if (free_depth != 0) begin
                    // Reuse the most recently freed id with its version bumped.
                    free_depth--;
                    gid = free_ids[free_depth];
                    slot_ver[gid] = slot_ver[gid] + 8'd1;
                end else if (top_id != TOP_ID) begin
                    top_id = top_id + 10'd1;
                    gid = top_id;
                    slot_ver[gid] = 8'd0;
                end else begin
                    granted = 1'b0;
                    gid = 10'd0;
                    r.status = STS_FULL;
                end
                if (granted) begin
                    slot_live[gid] = 1'b1;
                    slot_pay[gid] = pay;
                    r.id = gid;
                    r.ver = slot_ver[gid];
                    live_ids.push_back(gid);
                end
            end
            ACT_RECYCLE: begin
                if (slot_live[id] && slot_ver[id] == ver) begin
                    slot_live[id] = 1'b0;
                    free_ids[free_depth] = id;
                    free_depth++;
                    foreach (live_ids[k]) begin
                        if (live_ids[k] == id) begin
                            live_ids.delete(k);
                            break;
                        end
                    end
                    last_freed_id = id;
                    last_freed_ver = ver;
                end else begin
                    r.status = STS_STALE;
                end
            end
            ACT_LOOKUP: begin
                if (slot_live[id] && slot_ver[id] == ver)
                    r.pay = slot_pay[id];
                else
                    r.status = STS_STALE;
            end
            ACT_RESERVE: begin
                // Every 10-bit id is in range, so a reserve always succeeds.
                if (top_id < id)
                    top_id = id;
            end
        endcase
        return r;
    endfunction

    function automatic int next_gap();
        if (run_left == 0) begin
            run_left = $urandom_range(20, 60);
            run_dense = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return run_dense ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            fail_count++;
        end
    endtask

    // Each result beat is matched against the oldest outstanding expectation.
    always @(posedge i_clk) begin : monitor
        t_handle_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected, actual %h", $realtime,
                         {o_status, o_out_id, o_out_version, o_out_payload});
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("out_id", want.id, o_out_id);
                check_field("out_version", want.ver, o_out_version);
                check_field("out_payload", want.pay, o_out_payload);
            end
        end
    end

    // Drives one request beat and returns at the edge that takes it, with the
    // shadow state already advanced for that beat. Inputs move only on falling
    // edges; start is lowered during a gap or a wait for results and otherwise
    // stays high from one beat to the next.
    task automatic send_request(input t_action act, input logic [9:0] id,
                                input logic [7:0] ver, input logic [31:0] pay,
                                input bit pin, input t_handle_result pinned);
        int             gap;
        t_handle_result want;
        gap = next_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_action <= act;
        i_handle_id <= id;
        i_handle_version <= ver;
        i_payload <= pay;
        do @(posedge i_clk); while (o_busy);
        want = predict_handle_op(act, id, ver, pay);
        if (pin)
            want = pinned;
        pending_results.push_back(want);
    endtask

    // Holds the request side off until every outstanding result has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Builds one random request. Most recycles and lookups use a live handle
    // with its right version; the rest use the last freed handle or noise.
    // Reserve ids are capped by a limit that grows over the run, so fresh
    // grants stay possible for most of it.
    task automatic send_random(input int n);
        int         pick;
        int         roll;
        int         grant_weight;
        t_action    act;
        logic [9:0] id;
        logic [7:0] ver;
        logic [31:0] pay;
        pay = $urandom;
        id = $urandom_range(0, NUM_IDS - 1);
        ver = $urandom_range(0, 255);
        pick = $urandom_range(0, 99);
        grant_weight = (live_ids.size() < 24) ? 45 : 25;
        if (pick < grant_weight) begin
            act = ACT_GRANT;
        end else if (pick < 90) begin
            act = (pick < grant_weight + (90 - grant_weight) / 2) ? ACT_RECYCLE : ACT_LOOKUP;
            roll = $urandom_range(0, 9);
            if (roll < 8 && live_ids.size() != 0) begin
                id = live_ids[$urandom_range(0, live_ids.size() - 1)];
                ver = slot_ver[id];
            end else if (roll == 8) begin
                id = last_freed_id;
                ver = last_freed_ver;
            end
        end else if (pick < 95) begin
            act = ACT_RESERVE;
            id = $urandom_range(0, 8 + n * (NUM_IDS - 9) / RANDOM_OPS);
        end else begin
            act = t_action'($urandom_range(0, 2));
        end
        send_request(act, id, ver, pay, 1'b0, '0);
    endtask

    // Directed sequence from reset: fresh grants, lookups with good and bad
    // handles, a version mismatch, a double free, reuse of freed ids in
    // last-in first-out order, and reserves that raise or leave the counter.
    t_request_row directed_rows [24] = '{
        '{ACT_GRANT,   10'h3FF, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{STS_OK, 10'd1, 8'd0, 32'd0}},
        '{ACT_GRANT,   10'h000, 8'h00, 32'h0000_0000, 1'b1, '{STS_OK, 10'd2, 8'd0, 32'd0}},
        '{ACT_LOOKUP,  10'd1,   8'd0,  32'h1234_5678, 1'b1,
          '{STS_OK, 10'd1, 8'd0, 32'hFFFF_FFFF}},
        '{ACT_LOOKUP,  10'd2,   8'd0,  32'hFFFF_FFFF, 1'b1, '{STS_OK, 10'd2, 8'd0, 32'd0}},
        '{ACT_LOOKUP,  10'd1,   8'hFF, 32'd0,         1'b1,
          '{STS_STALE, 10'd1, 8'hFF, 32'd0}},
        '{ACT_LOOKUP,  10'd0,   8'd0,  32'd0,         1'b1, '{STS_STALE, 10'd0, 8'd0, 32'd0}},
        '{ACT_LOOKUP,  10'h3FF, 8'hFF, 32'd0,         1'b1,
          '{STS_STALE, 10'h3FF, 8'hFF, 32'd0}},
        '{ACT_RECYCLE, 10'd2,   8'd1,  32'd0,         1'b1, '{STS_STALE, 10'd2, 8'd1, 32'd0}},
        '{ACT_RECYCLE, 10'd1,   8'd0,  32'd0,         1'b1, '{STS_OK, 10'd1, 8'd0, 32'd0}},
        '{ACT_RECYCLE, 10'd1,   8'd0,  32'd0,         1'b1, '{STS_STALE, 10'd1, 8'd0, 32'd0}},
        '{ACT_LOOKUP,  10'd1,   8'd0,  32'd0,         1'b1, '{STS_STALE, 10'd1, 8'd0, 32'd0}},
        '{ACT_GRANT,   10'h155, 8'hAA, 32'hA5A5_A5A5, 1'b0, '0},
        '{ACT_LOOKUP,  10'd1,   8'd1,  32'd0,         1'b0, '0},
        '{ACT_RESERVE, 10'd5,   8'hFF, 32'hFFFF_FFFF, 1'b1, '{STS_OK, 10'd5, 8'hFF, 32'd0}},
        '{ACT_GRANT,   10'h2AA, 8'h55, 32'h5A5A_5A5A, 1'b1, '{STS_OK, 10'd6, 8'd0, 32'd0}},
        '{ACT_RESERVE, 10'd3,   8'd0,  32'd0,         1'b1, '{STS_OK, 10'd3, 8'd0, 32'd0}},
        '{ACT_GRANT,   10'd0,   8'd0,  32'h0F0F_0F0F, 1'b1, '{STS_OK, 10'd7, 8'd0, 32'd0}},
        '{ACT_RESERVE, 10'd0,   8'd0,  32'd0,         1'b1, '{STS_OK, 10'd0, 8'd0, 32'd0}},
        '{ACT_GRANT,   10'd0,   8'd0,  32'hF0F0_F0F0, 1'b1, '{STS_OK, 10'd8, 8'd0, 32'd0}},
        '{ACT_RECYCLE, 10'd6,   8'd0,  32'd0,         1'b1, '{STS_OK, 10'd6, 8'd0, 32'd0}},
        '{ACT_RECYCLE, 10'd7,   8'd0,  32'd0,         1'b1, '{STS_OK, 10'd7, 8'd0, 32'd0}},
        '{ACT_GRANT,   10'd0,   8'd0,  32'h0000_0001, 1'b0, '0},
        '{ACT_GRANT,   10'd0,   8'd0,  32'h8000_0000, 1'b0, '0},
        '{ACT_RECYCLE, 10'd0,   8'd0,  32'd0,         1'b1, '{STS_STALE, 10'd0, 8'd0, 32'd0}}
    };

    initial begin
        // Synchronous reset at start. The block then sweeps its table
        // with busy high, which the first request simply waits out.
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_request(directed_rows[r].act, directed_rows[r].id, directed_rows[r].ver,
                         directed_rows[r].pay, directed_rows[r].pinned, directed_rows[r].res);

        // Free and regrant id 1 until its version has wrapped past 255. The
        // free stack is last-in first-out, so each grant takes id 1 back.
        repeat (WRAP_PAIRS) begin
            send_request(ACT_RECYCLE, 10'd1, slot_ver[1], $urandom, 1'b0, '0);
            send_request(ACT_GRANT, $urandom_range(0, NUM_IDS - 1), $urandom_range(0, 255),
                         $urandom, 1'b0, '0);
        end
        wait_for_results();

        for (int n = 0; n < RANDOM_OPS; n++) begin
            send_random(n);
            if (n % 300 == 299)
                wait_for_results();
        end
        wait_for_results();

        // Table full: push the counter up so that one fresh id is left at
        // most, drain the free stack, and then grant twice more, reserve the top id and look it up.
        send_request(ACT_RESERVE, TOP_ID - 10'd1, $urandom_range(0, 255), $urandom,
                     1'b0, '0);
        while (free_depth != 0 || top_id != TOP_ID)
            send_request(ACT_GRANT, 10'd0, 8'd0, $urandom, 1'b0, '0);
        send_request(ACT_GRANT, 10'h2AA, 8'h55, $urandom, 1'b1,
                     '{STS_FULL, 10'h2AA, 8'h55, 32'd0});
        send_request(ACT_GRANT, 10'h155, 8'hAA, $urandom, 1'b1,
                     '{STS_FULL, 10'h155, 8'hAA, 32'd0});
        send_request(ACT_RESERVE, TOP_ID, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                     '{STS_OK, TOP_ID, 8'hFF, 32'd0});
        send_request(ACT_LOOKUP, TOP_ID, 8'd0, $urandom, 1'b0, '0);

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // This bound on the whole run catches a hang.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
